/* rtl/segsum_pkg.sv */
package segsum_pkg;

    // Field widths of the request and response items.
    localparam int POS_W   = 11;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 42;

    // Request command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [POS_W-1:0]          range_first;
        logic [POS_W-1:0]          range_last;
        logic [POS_W-1:0]          set_position;
        logic signed [VALUE_W-1:0] set_value;
    } req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_sum;
    } rsp_t;

endpackage

/* rtl/segsum_stream_if.sv */
interface segsum_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/segsum_ram.sv */
module segsum_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

/* rtl/segment_tree_range_sum_unit.sv */
// A query's sum is posted once the bottom-up walk from its two range ends has met. The unit
// works on one request item at a time, and its node memory has a single port pair.
// A finished result waits in the output register while the next request is taken; a later
// query then holds at its result step until the register is free. Reset: rst_n is
// asynchronous, active low; a clearing pass then zeroes all 2*LEAVES nodes, one per cycle.
module segment_tree_range_sum_unit #(
    parameter int LEAVES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    segsum_stream_if.sink   req,
    segsum_stream_if.source rsp
);
    import segsum_pkg::*;

    // Node k has children 2k and 2k+1, the root is node 1 and position p sits in
    // leaf node LEAVES+p-1. Entry 0 of the memory is never used.
    localparam int DEPTH = 2 * LEAVES;
    localparam int AW    = $clog2(DEPTH);
    // The right walk bound starts one past the last leaf, so it needs one more value.
    localparam int NW    = $clog2(DEPTH + 1);
    // Width in which an input position is compared against LEAVES.
    localparam int CW    = (POS_W > NW) ? POS_W : NW;

    // The sequencer runs a small program. Each step holds one control word: the
    // datapath operation, a jump condition with its target, and an end-of-item flag.
    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_INIT,
        ACT_LEFT,
        ACT_RIGHT,
        ACT_SHIFT,
        ACT_RESULT,
        ACT_LEAF_RD,
        ACT_LEAF_WR,
        ACT_NODE_RD,
        ACT_NODE_WR
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IS_LOAD,
        C_L_GE_R,
        C_POS_BAD,
        C_NOT_ROOT
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
        logic  last;
    } uword_t;

    localparam step_t S_INIT    = 4'd0;
    localparam step_t S_LEFT    = 4'd1;
    localparam step_t S_RIGHT   = 4'd2;
    localparam step_t S_SHIFT   = 4'd3;
    localparam step_t S_RESULT  = 4'd4;
    localparam step_t S_LEAF_RD = 4'd5;
    localparam step_t S_LEAF_WR = 4'd6;
    localparam step_t S_NODE_RD = 4'd7;
    localparam step_t S_NODE_WR = 4'd8;
    localparam step_t S_END     = 4'd9;

    // The microprogram. A query walks the tree bottom-up from both range ends
    // (three steps per level), posts its sum, and then falls into the update.
    // The update reads the leaf, forms the change against the new value, and
    // adds that change to each ancestor with a read step and a write step.
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        unique case (s)
            S_INIT:    w = '{act: ACT_INIT,    cond: C_IS_LOAD,  target: S_LEAF_RD, last: 1'b0};
            S_LEFT:    w = '{act: ACT_LEFT,    cond: C_L_GE_R,   target: S_RESULT,  last: 1'b0};
            S_RIGHT:   w = '{act: ACT_RIGHT,   cond: C_NEVER,    target: S_INIT,    last: 1'b0};
            S_SHIFT:   w = '{act: ACT_SHIFT,   cond: C_ALWAYS,   target: S_LEFT,    last: 1'b0};
            S_RESULT:  w = '{act: ACT_RESULT,  cond: C_NEVER,    target: S_INIT,    last: 1'b0};
            S_LEAF_RD: w = '{act: ACT_LEAF_RD, cond: C_POS_BAD,  target: S_END,     last: 1'b0};
            S_LEAF_WR: w = '{act: ACT_LEAF_WR, cond: C_ALWAYS,   target: S_NODE_RD, last: 1'b0};
            S_NODE_RD: w = '{act: ACT_NODE_RD, cond: C_NEVER,    target: S_INIT,    last: 1'b0};
            S_NODE_WR: w = '{act: ACT_NODE_WR, cond: C_NOT_ROOT, target: S_NODE_RD, last: 1'b0};
            default:   w = '{act: ACT_NOP,     cond: C_NEVER,    target: S_INIT,    last: 1'b1};
        endcase
        return w;
    endfunction

    // Out-of-range ends saturate to the first or the last position.
    function automatic logic [NW-1:0] clamp_pos(input logic [POS_W-1:0] p);
        logic [CW-1:0] pe;
        pe = CW'(p);
        if (pe == '0)
        begin
            return NW'(1);
        end
        else if (pe > CW'(LEAVES))
        begin
            return NW'(LEAVES);
        end
        return pe[NW-1:0];
    endfunction

    // Control state.
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          busy_reg, busy_next;
    step_t         step_reg, step_next;
    logic          pend_reg, pend_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // Payload state.
    req_t             req_reg, req_next;
    logic [NW-1:0]    l_reg, l_next;
    logic [NW-1:0]    r_reg, r_next;
    logic [AW-1:0]    node_reg, node_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] delta_reg, delta_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    // Datapath signals.
    uword_t           uw;
    logic             accept;
    logic             active;
    logic             stall;
    logic             cond_hit;
    logic             pos_bad;
    logic [NW-1:0]    first_c;
    logic [NW-1:0]    last_c;
    logic [CW-1:0]    pos_ext;
    logic [CW-1:0]    leaf_full;
    logic [NW-1:0]    r_minus;
    logic [SUM_W-1:0] value_ext;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [SUM_W-1:0] ram_wr_data;
    logic [AW-1:0]    ram_rd_addr;
    logic [SUM_W-1:0] ram_rd_data;

    // Requests are taken only when no item is in flight and the clearing pass is over.
    assign req.ready = !busy_reg && !clr_active_reg;
    assign accept    = req.valid && req.ready;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    assign uw = ucode_rom(step_reg);

    // Posting a result waits while the output register still holds an untaken one.
    assign stall  = (uw.act == ACT_RESULT) && rsp_valid_reg && !rsp.ready;
    assign active = busy_reg && !stall;

    assign first_c   = clamp_pos(req_reg.range_first);
    assign last_c    = clamp_pos(req_reg.range_last);
    assign pos_ext   = CW'(req_reg.set_position);
    assign pos_bad   = (pos_ext == '0) || (pos_ext > CW'(LEAVES));
    assign leaf_full = CW'(LEAVES) + pos_ext - CW'(1);
    assign r_minus   = r_reg - NW'(1);
    assign value_ext = {{(SUM_W - VALUE_W){req_reg.set_value[VALUE_W-1]}}, req_reg.set_value};

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_IS_LOAD:  cond_hit = (req_reg.command == CMD_LOAD);
            C_L_GE_R:   cond_hit = (l_reg >= r_reg);
            C_POS_BAD:  cond_hit = pos_bad;
            C_NOT_ROOT: cond_hit = (node_reg != AW'(1));
            default:    cond_hit = 1'b0;
        endcase
    end

    // Memory ports. The clearing pass owns the write port until it finishes.
    always_comb
    begin
        ram_wr_en   = clr_active_reg;
        ram_wr_addr = clr_addr_reg;
        ram_wr_data = '0;
        if (!clr_active_reg && active)
        begin
            if (uw.act == ACT_LEAF_WR)
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = node_reg;
                ram_wr_data = value_ext;
            end
            else if (uw.act == ACT_NODE_WR)
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = node_reg;
                ram_wr_data = ram_rd_data + delta_reg;
            end
        end
    end

    always_comb
    begin
        case (uw.act)
            ACT_LEFT:  ram_rd_addr = l_reg[AW-1:0];
            ACT_RIGHT: ram_rd_addr = r_minus[AW-1:0];
            default:   ram_rd_addr = node_reg;
        endcase
    end

    segsum_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        busy_next       = busy_reg;
        step_next       = step_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        req_next        = req_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        node_next       = node_reg;
        sum_next        = sum_reg;
        delta_next      = delta_reg;
        rsp_data_next   = rsp_data_reg;

        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
            step_next = S_INIT;
            req_next  = req.payload;
        end
        else if (active)
        begin
            if (uw.last)
            begin
                busy_next = 1'b0;
            end
            else if (cond_hit)
            begin
                step_next = uw.target;
            end
            else
            begin
                step_next = step_reg + step_t'(1);
            end

            // A node read in the previous step lands now and joins the sum.
            pend_next = 1'b0;
            if (pend_reg)
            begin
                sum_next = sum_reg + ram_rd_data;
            end

            unique case (uw.act)
                ACT_INIT:
                begin
                    // Order the clamped ends, then place both walk bounds on the leaf row.
                    if (first_c > last_c)
                    begin
                        l_next = NW'(LEAVES) + last_c - NW'(1);
                        r_next = NW'(LEAVES) + first_c;
                    end
                    else
                    begin
                        l_next = NW'(LEAVES) + first_c - NW'(1);
                        r_next = NW'(LEAVES) + last_c;
                    end
                    node_next = leaf_full[AW-1:0];
                    sum_next  = '0;
                end
                ACT_LEFT:
                begin
                    // A left bound that is a right child is taken alone and stepped past.
                    if ((l_reg < r_reg) && l_reg[0])
                    begin
                        pend_next = 1'b1;
                        l_next    = l_reg + NW'(1);
                    end
                end
                ACT_RIGHT:
                begin
                    if (r_reg[0])
                    begin
                        pend_next = 1'b1;
                        r_next    = r_minus;
                    end
                end
                ACT_SHIFT:
                begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
                ACT_RESULT:
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_data_next.range_sum = sum_reg;
                end
                ACT_LEAF_WR:
                begin
                    delta_next = value_ext - ram_rd_data;
                    node_next  = node_reg >> 1;
                end
                ACT_NODE_WR:
                begin
                    node_next = node_reg >> 1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            busy_reg       <= 1'b0;
            step_reg       <= S_INIT;
            pend_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            pend_reg       <= pend_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        node_reg     <= node_next;
        sum_reg      <= sum_next;
        delta_reg    <= delta_next;
        rsp_data_reg <= rsp_data_next;
    end
endmodule

/* rtl/segsum_checker.sv */
module segsum_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input segsum_pkg::rsp_t  rsp_payload
);
    import segsum_pkg::*;

    // The clearing pass keeps requests out right after reset.
    a_no_req_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !req_ready)
        else $error("request taken during the clearing pass");

    // A transfer occupies the block, so ready must drop after it.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is still in flight");

    // A new result is posted only while its item is still being worked on.
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !$past(rsp_valid) |-> !req_ready)
        else $error("result appeared with no item in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("stalled result changed or vanished");
endmodule

bind segment_tree_range_sum_unit segsum_checker u_segsum_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

/* tb/segment_tree_range_sum_unit_tb.sv */
module segment_tree_range_sum_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import segsum_pkg::*;

    localparam int LEAVES = 1024;

    // Highest value that fits in a position field; used to push range ends and
    // set positions beyond the last leaf.
    localparam logic [POS_W-1:0] POS_ALL_ONES = '1;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // Once this many range sums have come back, the receiver holds off for a
    // long stretch so that the block backs up and stalls its request side.
    localparam int LONG_HOLD_AFTER  = 150;
    localparam int LONG_HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    segsum_stream_if #(.payload_t(req_t)) req_if ();
    segsum_stream_if #(.payload_t(rsp_t)) rsp_if ();

    segment_tree_range_sum_unit #(
        .LEAVES(LEAVES)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if.sink),
        .rsp  (rsp_if.source)
    );

    // Requests waiting to be offered to the block, filled by the stimulus
    // process and drained by the request driver.
    req_t pending_reqs[$];
    int unsigned queued_count = 0;
    int unsigned sent_count = 0;

    // Range sums that the block owes us, oldest first.
    logic signed [SUM_W-1:0] range_sum_due[$];
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    // Our own picture of the tree: the value held at every position. A range
    // sum is simply the sum of the positions it covers, which is the same as
    // the tree walk modulo the width of the result.
    longint leaf_value[1:LEAVES];

    // Set near the end of the run so that neither side idles any more.
    logic quiet_tail = 1'b0;

    // Request side idling state.
    int unsigned send_gap = 0;
    int unsigned send_idle_pct = 0;
    logic [7:0] send_cycle = '0;

    // Response side stalling state.
    int unsigned recv_stall = 0;
    int unsigned recv_idle_pct = 0;
    logic [7:0] recv_cycle = '0;
    int unsigned long_hold_left = 0;
    logic long_hold_done = 1'b0;

    logic signed [SUM_W-1:0] wanted_sum;

    // Picks how eagerly a side idles for the next stretch of cycles. The zero
    // case gives stretches with no idling at all.
    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 45;
        endcase
    endfunction

    // Range ends saturate into 1..LEAVES before the sum is taken.
    function automatic int unsigned saturate_end(logic [POS_W-1:0] pos_end);
        if (pos_end < 1)
            return 1;
        if (pos_end > LEAVES)
            return LEAVES;
        return pos_end;
    endfunction

    function automatic req_t make_req(logic cmd, int unsigned first, int unsigned last,
                                      int unsigned pos, logic signed [VALUE_W-1:0] value);
        req_t item;
        item.command      = cmd;
        item.range_first  = first[POS_W-1:0];
        item.range_last   = last[POS_W-1:0];
        item.set_position = pos[POS_W-1:0];
        item.set_value    = value;
        return item;
    endfunction

    // Mostly in-range positions, with a share of raw field values that may
    // fall on zero or beyond the last leaf.
    function automatic int unsigned random_pos(int unsigned wild_pct);
        if ($urandom_range(0, 99) < wild_pct)
            return $urandom_range(0, 2047);
        return $urandom_range(1, LEAVES);
    endfunction

    function automatic req_t random_req(int unsigned query_pct);
        int unsigned first;
        int unsigned last;
        int unsigned shape;
        logic signed [VALUE_W-1:0] value;
        logic cmd;
        cmd = ($urandom_range(0, 99) < query_pct) ? CMD_QUERY : CMD_LOAD;
        shape = $urandom_range(0, 99);
        if (shape < 30)
        begin
            // A narrow range, sometimes written back to front.
            first = $urandom_range(1, LEAVES);
            last = (first > 16) ? first - $urandom_range(0, 16) : first + $urandom_range(0, 16);
        end
        else if (shape < 40)
        begin
            first = 1;
            last = LEAVES;
        end
        else
        begin
            first = random_pos(10);
            last = random_pos(10);
        end
        case ($urandom_range(0, 9))
            0: value = VALUE_MAX;
            1: value = VALUE_MIN;
            2, 3, 4, 5: value = $urandom;
            default: value = $signed($urandom_range(0, 2000)) - 1000;
        endcase
        return make_req(cmd, first, last, random_pos(8), value);
    endfunction

    // Applies one accepted request to our picture of the tree and records the
    // range sum that a query must return.
    task automatic apply_request(req_t item);
        int unsigned lo;
        int unsigned hi;
        int unsigned swap_tmp;
        longint total;
        if (item.command == CMD_QUERY)
        begin
            lo = saturate_end(item.range_first);
            hi = saturate_end(item.range_last);
            if (lo > hi)
            begin
                swap_tmp = lo;
                lo = hi;
                hi = swap_tmp;
            end
            total = 0;
            for (int unsigned p = lo; p <= hi; p++)
                total += leaf_value[p];
            range_sum_due.push_back(total[SUM_W-1:0]);
        end
        // A set position of zero or past the last leaf leaves the tree alone.
        if (item.set_position >= 1 && item.set_position <= LEAVES)
            leaf_value[item.set_position] = longint'($signed(item.set_value));
    endtask

    task automatic queue_req(req_t item);
        pending_reqs.push_back(item);
        queued_count++;
    endtask

    // Returns once every queued request has been taken and every range sum
    // that they owe has come back. Sampling on the falling edge keeps this
    // clear of the updates made at the rising edge.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || sent_count != queued_count ||
               range_sum_due.size() != 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reset is applied once, at the start. All block inputs are given known
    // values at time zero.
    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        for (int p = 1; p <= LEAVES; p++)
            leaf_value[p] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver. A transfer happens at an edge where valid and ready are
    // both high; the payload then moves on to the next pending request or
    // valid drops for an idle burst. While the block stalls, the offered
    // request is held unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.payload <= '0;
            send_gap = 0;
        end
        else
        begin
            send_cycle <= send_cycle + 1'b1;
            if (send_cycle == '0)
                send_idle_pct = pick_idle_pct();
            if (req_if.valid && req_if.ready)
            begin
                apply_request(req_if.payload);
                sent_count++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_if.payload <= pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    // The burst, if any, starts after this request's transfer.
                    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 17);
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and ready control. Every transfer on the response side
    // is checked against the oldest range sum still owed. The long hold-off
    // is counted here, in this process, while the driver keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            recv_cycle <= recv_cycle + 1'b1;
            if (recv_cycle == '0)
                recv_idle_pct = pick_idle_pct();
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen++;
                if (range_sum_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range sum %0d arrived with none owed",
                                 rsp_if.payload.range_sum);
                end
                else
                begin
                    wanted_sum = range_sum_due.pop_front();
                    if (rsp_if.payload.range_sum !== wanted_sum)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("range sum mismatch: expected %0d, got %0d",
                                     wanted_sum, rsp_if.payload.range_sum);
                    end
                end
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_if.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_stall = $urandom_range(1, 17) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);

        // Directed part: extreme values at both ends of the tree, a full range
        // both ways round, saturating range ends, and set positions that fall
        // outside the tree for both loads and queries.
        queue_req(make_req(CMD_LOAD, 0, 0, 1, VALUE_MAX));
        queue_req(make_req(CMD_LOAD, 0, 0, LEAVES, VALUE_MIN));
        queue_req(make_req(CMD_LOAD, 0, 0, LEAVES / 2, -1));
        queue_req(make_req(CMD_LOAD, 0, 0, LEAVES / 2 + 1, 12345));
        queue_req(make_req(CMD_QUERY, 1, LEAVES, 2, 0));
        queue_req(make_req(CMD_QUERY, LEAVES, 1, 0, 7));
        queue_req(make_req(CMD_QUERY, 0, POS_ALL_ONES, POS_ALL_ONES, -7));
        queue_req(make_req(CMD_QUERY, 0, 0, LEAVES + 1, 99));
        queue_req(make_req(CMD_QUERY, POS_ALL_ONES, 1500, LEAVES, VALUE_MAX));
        queue_req(make_req(CMD_QUERY, LEAVES / 2, LEAVES / 2 + 1, LEAVES / 2, VALUE_MIN));
        queue_req(make_req(CMD_QUERY, LEAVES / 2, LEAVES / 2, LEAVES / 2 + 1, 0));
        queue_req(make_req(CMD_LOAD, POS_ALL_ONES, POS_ALL_ONES, 0, 5));
        queue_req(make_req(CMD_LOAD, 0, 0, POS_ALL_ONES, 5));
        queue_req(make_req(CMD_LOAD, 0, 0, LEAVES + 1, 5));
        queue_req(make_req(CMD_QUERY, 1, LEAVES, 3, 1));
        queue_req(make_req(CMD_QUERY, LEAVES, LEAVES, 1, VALUE_MIN));
        queue_req(make_req(CMD_QUERY, 2, LEAVES - 1, LEAVES - 1, -1));
        queue_req(make_req(CMD_QUERY, 1, 1, 1, 0));
        wait_drained();

        // First random phase leans on loads to fill the tree.
        for (int i = 0; i < 600; i++)
            queue_req(random_req(45));

        // The sender pauses here until every owed range sum has arrived.
        wait_drained();

        for (int i = 0; i < 830; i++)
            queue_req(random_req(55));

        // The last stretch runs with both sides always willing.
        do
            @(negedge clk);
        while (pending_reqs.size() >= 150);
        quiet_tail = 1'b1;

        wait_drained();
        // Leave room for any stray result the block might still produce.
        repeat (120) @(negedge clk);

        if (mismatches == 0 && range_sum_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Safety net far beyond the slowest correct run, clearing pass included.
    initial
    begin
        #(10ms);
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/segsum_pkg.sv
rtl/segsum_stream_if.sv
rtl/segsum_ram.sv
rtl/segment_tree_range_sum_unit.sv
rtl/segsum_checker.sv
tb/segment_tree_range_sum_unit_tb.sv
